FILE: hw/rtl/rcss_pkg.sv
package rcss_pkg;

  localparam int ADDR_W = 5;
  localparam int DIV_W = 32;
  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = 4;

  localparam logic [29:0] TARGET_RST = 30'd868000000;
  localparam logic [29:0] BOOT_RST = 30'd868000000;
  localparam logic [29:0] MIN_RST = 30'd860000000;
  localparam logic [29:0] MAX_RST = 30'd923000000;
  localparam logic [29:0] LMIN_RST = 30'd863000000;
  localparam logic [29:0] LMAX_RST = 30'd870000000;
  localparam logic [23:0] CW_RST = 24'd250000;

  localparam logic [7:0] CHG_MARK = 8'h56;
  localparam logic signed [15:0] FAIL_MAX = 16'sd32767;

  localparam logic [1:0] CMD_RX = 2'd1;
  localparam logic [1:0] CMD_FETCH = 2'd2;

  localparam logic [2:0] REG_TARGET = 3'd0;
  localparam logic [2:0] REG_BOOT = 3'd1;
  localparam logic [2:0] REG_MIN = 3'd2;
  localparam logic [2:0] REG_MAX = 3'd3;
  localparam logic [2:0] REG_LMIN = 3'd4;
  localparam logic [2:0] REG_LMAX = 3'd5;
  localparam logic [2:0] REG_CW = 3'd6;

  localparam logic [1:0] DIV_OFF = 2'd0;
  localparam logic [1:0] DIV_LO = 2'd1;
  localparam logic [1:0] DIV_HI = 2'd2;
  localparam logic [1:0] DIV_MOD = 2'd3;

  localparam logic [1:0] SRC_SIMPLE = 2'd0;
  localparam logic [1:0] SRC_TARGET = 2'd1;
  localparam logic [1:0] SRC_SEARCH = 2'd2;

  typedef struct packed {
    logic [29:0] target;
    logic [29:0] boot;
    logic [29:0] fmin;
    logic [29:0] fmax;
    logic [29:0] lmin;
    logic [29:0] lmax;
    logic [23:0] cw;
  } cfg_t;

  typedef struct packed {
    logic       load_in;
    logic       div_start;
    logic [1:0] div_sel;
    logic       div_capture;
    logic       k_load;
    logic       prod_load;
    logic       finish;
    logic [1:0] src;
  } ctl_t;

  typedef struct packed {
    logic need_search;
    logic span_pos;
    logic div_done;
  } sts_t;

endpackage

FILE: hw/rtl/rcss_div.sv
module rcss_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [rcss_pkg::DIV_W-1:0] dividend,
  input  logic [rcss_pkg::DIV_W-1:0] divisor,
  output logic                       done,
  output logic [rcss_pkg::DIV_W-1:0] quot,
  output logic [rcss_pkg::DIV_W-1:0] rem
);

  logic                           busy_r;
  logic                           done_r;
  logic [rcss_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [rcss_pkg::DIV_W:0]       rem_r;
  logic [rcss_pkg::DIV_W:0]       rem_nxt;
  logic [rcss_pkg::DIV_W-1:0]     quo_r;
  logic [rcss_pkg::DIV_W-1:0]     quo_nxt;
  logic [rcss_pkg::DIV_W-1:0]     dvs_r;

  // Two restoring steps per cycle; the dividend shifts out of the quotient register.
  always_comb begin
    logic [rcss_pkg::DIV_W:0]   r1;
    logic [rcss_pkg::DIV_W:0]   r2;
    logic [rcss_pkg::DIV_W-1:0] q1;
    r1 = {rem_r[rcss_pkg::DIV_W-1:0], quo_r[rcss_pkg::DIV_W-1]};
    q1 = {quo_r[rcss_pkg::DIV_W-2:0], 1'b0};
    if (r1 >= {1'b0, dvs_r}) begin
      r1 = r1 - {1'b0, dvs_r};
      q1[0] = 1'b1;
    end
    r2 = {r1[rcss_pkg::DIV_W-1:0], q1[rcss_pkg::DIV_W-1]};
    quo_nxt = {q1[rcss_pkg::DIV_W-2:0], 1'b0};
    if (r2 >= {1'b0, dvs_r}) begin
      r2 = r2 - {1'b0, dvs_r};
      quo_nxt[0] = 1'b1;
    end
    rem_nxt = r2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == rcss_pkg::DIV_CNT_W'(rcss_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem = rem_r[rcss_pkg::DIV_W-1:0];

endmodule

FILE: hw/rtl/rcss_cfg.sv
module rcss_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rcss_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output rcss_pkg::cfg_t              cfg
);

  rcss_pkg::cfg_t cfg_r;
  logic [2:0]     idx;
  logic           wr;

  assign idx = paddr[rcss_pkg::ADDR_W-1:2];
  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target <= rcss_pkg::TARGET_RST;
      cfg_r.boot <= rcss_pkg::BOOT_RST;
      cfg_r.fmin <= rcss_pkg::MIN_RST;
      cfg_r.fmax <= rcss_pkg::MAX_RST;
      cfg_r.lmin <= rcss_pkg::LMIN_RST;
      cfg_r.lmax <= rcss_pkg::LMAX_RST;
      cfg_r.cw <= rcss_pkg::CW_RST;
    end else if (wr) begin
      case (idx)
        rcss_pkg::REG_TARGET: cfg_r.target <= pwdata[29:0];
        rcss_pkg::REG_BOOT:   cfg_r.boot <= pwdata[29:0];
        rcss_pkg::REG_MIN:    cfg_r.fmin <= pwdata[29:0];
        rcss_pkg::REG_MAX:    cfg_r.fmax <= pwdata[29:0];
        rcss_pkg::REG_LMIN:   cfg_r.lmin <= pwdata[29:0];
        rcss_pkg::REG_LMAX:   cfg_r.lmax <= pwdata[29:0];
        rcss_pkg::REG_CW:     cfg_r.cw <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      rcss_pkg::REG_TARGET: prdata = {2'b0, cfg_r.target};
      rcss_pkg::REG_BOOT:   prdata = {2'b0, cfg_r.boot};
      rcss_pkg::REG_MIN:    prdata = {2'b0, cfg_r.fmin};
      rcss_pkg::REG_MAX:    prdata = {2'b0, cfg_r.fmax};
      rcss_pkg::REG_LMIN:   prdata = {2'b0, cfg_r.lmin};
      rcss_pkg::REG_LMAX:   prdata = {2'b0, cfg_r.lmax};
      rcss_pkg::REG_CW:     prdata = {8'b0, cfg_r.cw};
      default:              prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

FILE: hw/rtl/rcss_ctrl.sv
module rcss_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  rcss_pkg::sts_t        sts,
  output rcss_pkg::ctl_t        ctl
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_DIV = 3'd2;
  localparam logic [2:0] S_NEXT = 3'd3;
  localparam logic [2:0] S_MUL = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic [1:0] sel_r;
  logic [1:0] sel_nxt;
  logic [1:0] src_r;
  logic [1:0] src_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    sel_nxt = sel_r;
    src_nxt = src_r;
    ctl = '0;
    ctl.div_sel = sel_r;
    ctl.src = src_r;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load_in = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.need_search) begin
          sel_nxt = rcss_pkg::DIV_OFF;
          ctl.div_sel = rcss_pkg::DIV_OFF;
          ctl.div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          src_nxt = rcss_pkg::SRC_SIMPLE;
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          ctl.div_capture = 1'b1;
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        case (sel_r)
          rcss_pkg::DIV_OFF: begin
            sel_nxt = rcss_pkg::DIV_LO;
            ctl.div_sel = rcss_pkg::DIV_LO;
            ctl.div_start = 1'b1;
            state_nxt = S_DIV;
          end
          rcss_pkg::DIV_LO: begin
            sel_nxt = rcss_pkg::DIV_HI;
            ctl.div_sel = rcss_pkg::DIV_HI;
            ctl.div_start = 1'b1;
            state_nxt = S_DIV;
          end
          rcss_pkg::DIV_HI: begin
            if (sts.span_pos) begin
              sel_nxt = rcss_pkg::DIV_MOD;
              ctl.div_sel = rcss_pkg::DIV_MOD;
              ctl.div_start = 1'b1;
              state_nxt = S_DIV;
            end else begin
              src_nxt = rcss_pkg::SRC_TARGET;
              state_nxt = S_DONE;
            end
          end
          default: begin
            ctl.k_load = 1'b1;
            state_nxt = S_MUL;
          end
        endcase
      end
      S_MUL: begin
        ctl.prod_load = 1'b1;
        src_nxt = rcss_pkg::SRC_SEARCH;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          ctl.finish = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (ctl.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r <= rcss_pkg::DIV_OFF;
      src_r <= rcss_pkg::SRC_SIMPLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r <= sel_nxt;
      src_r <= src_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: hw/rtl/rcss_dp.sv
module rcss_dp #(
  parameter int SEARCH_SPAN = 20
) (
  input  logic           clk,
  input  logic           rst_n,
  input  rcss_pkg::ctl_t ctl,
  output rcss_pkg::sts_t sts,
  input  rcss_pkg::cfg_t cfg,
  input  logic [1:0]     in_command,
  input  logic           in_reachable,
  input  logic [7:0]     in_send_count,
  input  logic [7:0]     in_payload_first_byte,
  input  logic           in_fragment_ok,
  output logic [29:0]    out_tx_freq,
  output logic [29:0]    out_rx_freq,
  output logic           out_send_change_channel,
  output logic [29:0]    out_good_freq_out
);

  localparam int OFF_W = $clog2(SEARCH_SPAN);

  logic [1:0]        cmd_r;
  logic              reach_r;
  logic [7:0]        sends_r;
  logic              change_r;
  logic              ok_r;
  logic [OFF_W-1:0]  off_r;
  logic [29:0]       q1_r;
  logic [29:0]       q2_r;
  logic [31:0]       mod_r;
  logic [31:0]       k_r;
  logic [31:0]       prod_r;
  logic [29:0]       lg_r;
  logic [29:0]       lg_nxt;
  logic signed [15:0] fc_r;
  logic signed [15:0] fc_nxt;
  logic [29:0]       tx_r;
  logic [29:0]       rx_r;
  logic              scc_r;

  logic              fc_pos;
  logic              simple_br;
  logic [29:0]       f_simple;
  logic [29:0]       f_search;
  logic [29:0]       f_sel;
  logic [29:0]       tx;
  logic [29:0]       rx;
  logic              scc;
  logic [29:0]       lo_u;
  logic [29:0]       hi_u;
  logic [30:0]       a;
  logic [30:0]       b;
  logic [30:0]       a_abs;
  logic [30:0]       b_abs;
  logic [31:0]       lo_off;
  logic [31:0]       hi_off;
  logic [32:0]       span;
  logic [31:0]       off_s;
  logic [31:0]       x;
  logic [31:0]       x_mag;
  logic [31:0]       sum_off;
  logic [32:0]       m;
  logic [32:0]       k;
  logic [31:0]       div_a;
  logic [31:0]       div_b;
  logic              div_done;
  logic [31:0]       div_q;
  logic [31:0]       div_r;

  assign fc_pos = !fc_r[15] && (fc_r != 16'sd0);
  assign simple_br = reach_r || !fc_pos;

  always_comb begin
    if (!simple_br) begin
      f_simple = cfg.target;
    end else if ((lg_r == cfg.target) || (lg_r == 30'd0)) begin
      f_simple = cfg.target;
    end else begin
      f_simple = sends_r[0] ? lg_r : cfg.target;
    end
  end

  assign sts.need_search = !simple_br && (sends_r != 8'd1) && (cfg.cw != 24'd0);

  assign lo_u = (cfg.fmin > cfg.lmin) ? cfg.fmin : cfg.lmin;
  assign hi_u = (cfg.fmax < cfg.lmax) ? cfg.fmax : cfg.lmax;
  assign a = {1'b0, cfg.target} - {1'b0, lo_u};
  assign b = {1'b0, hi_u} - {1'b0, cfg.target};
  assign a_abs = a[30] ? (31'd0 - a) : a;
  assign b_abs = b[30] ? (31'd0 - b) : b;

  assign lo_off = a[30] ? {2'b0, q1_r} : (32'd0 - {2'b0, q1_r});
  assign hi_off = b[30] ? (32'd0 - {2'b0, q2_r}) : {2'b0, q2_r};
  assign span = {hi_off[31], hi_off} + 33'd1 - {lo_off[31], lo_off};
  assign sts.span_pos = !span[32] && (span != 33'd0);

  assign off_s = sends_r[0] ? 32'(off_r) : (32'd0 - 32'(off_r));
  assign x = off_s - lo_off;
  assign x_mag = x[31] ? (32'd0 - x) : x;

  assign sum_off = 32'(fc_r[14:0]) + 32'(sends_r[7:1]) - 32'd2;

  always_comb begin
    case (ctl.div_sel)
      rcss_pkg::DIV_OFF: begin
        div_a = sum_off;
        div_b = 32'(SEARCH_SPAN);
      end
      rcss_pkg::DIV_LO: begin
        div_a = {2'b0, a_abs[29:0]};
        div_b = {8'b0, cfg.cw};
      end
      rcss_pkg::DIV_HI: begin
        div_a = {2'b0, b_abs[29:0]};
        div_b = {8'b0, cfg.cw};
      end
      default: begin
        div_a = x_mag;
        div_b = span[31:0];
      end
    endcase
  end

  rcss_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  assign sts.div_done = div_done;

  assign m = (x[31] && (mod_r != 32'd0)) ? (span - {1'b0, mod_r}) : {1'b0, mod_r};
  assign k = m + {lo_off[31], lo_off};
  assign f_search = cfg.target + prod_r[29:0];

  always_comb begin
    case (ctl.src)
      rcss_pkg::SRC_SEARCH: f_sel = f_search;
      rcss_pkg::SRC_TARGET: f_sel = cfg.target;
      default:              f_sel = f_simple;
    endcase
  end

  assign tx = change_r ? cfg.boot : f_sel;
  assign rx = change_r ? cfg.target : f_sel;
  assign scc = !reach_r || ((lg_r != 30'd0) && (lg_r != cfg.target));

  always_comb begin
    lg_nxt = lg_r;
    fc_nxt = fc_r;
    case (cmd_r)
      rcss_pkg::CMD_RX: begin
        if (ok_r) begin
          lg_nxt = rx;
          fc_nxt = -16'sd1;
        end
      end
      rcss_pkg::CMD_FETCH: begin
        if (reach_r) begin
          fc_nxt = 16'sd0;
        end else if (fc_r < rcss_pkg::FAIL_MAX) begin
          fc_nxt = fc_r + 16'sd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lg_r <= 30'd0;
      fc_r <= 16'sd0;
    end else if (ctl.finish) begin
      lg_r <= lg_nxt;
      fc_r <= fc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      cmd_r <= in_command;
      reach_r <= in_reachable;
      sends_r <= (in_send_count == 8'd0) ? 8'd1 : in_send_count;
      change_r <= (in_payload_first_byte == rcss_pkg::CHG_MARK);
      ok_r <= in_fragment_ok;
    end
    if (ctl.div_capture) begin
      case (ctl.div_sel)
        rcss_pkg::DIV_OFF: off_r <= div_r[OFF_W-1:0];
        rcss_pkg::DIV_LO:  q1_r <= div_q[29:0];
        rcss_pkg::DIV_HI:  q2_r <= div_q[29:0];
        default:           mod_r <= div_r;
      endcase
    end
    if (ctl.k_load) begin
      k_r <= k[31:0];
    end
    if (ctl.prod_load) begin
      prod_r <= k_r * {8'b0, cfg.cw};
    end
    if (ctl.finish) begin
      tx_r <= tx;
      rx_r <= rx;
      scc_r <= scc;
    end
  end

  assign out_tx_freq = tx_r;
  assign out_rx_freq = rx_r;
  assign out_send_change_channel = scc_r;
  assign out_good_freq_out = lg_r;

endmodule

FILE: hw/rtl/radio_channel_search_selector.sv
// A result is registered after its input transfer once any search is done and the output
// register is free; the zigzag search runs three or four divisions on one shared divider.
// One item at a time: the next transfer is taken once the result is registered, so the
// divider sets the rate for search queries and the control FSM for everything else.
// Reset (synchronous, rst_n low) restores the register defaults, clears the last good
// frequency and the failure count, and empties the output register.
module radio_channel_search_selector #(
  parameter int SEARCH_SPAN = 20
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_command,
  input  logic                        in_reachable,
  input  logic [7:0]                  in_send_count,
  input  logic [7:0]                  in_payload_first_byte,
  input  logic                        in_fragment_ok,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [29:0]                 out_tx_freq,
  output logic [29:0]                 out_rx_freq,
  output logic                        out_send_change_channel,
  output logic [29:0]                 out_good_freq_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rcss_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  rcss_pkg::cfg_t cfg;
  rcss_pkg::ctl_t ctl;
  rcss_pkg::sts_t sts;

  rcss_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rcss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  rcss_dp #(
    .SEARCH_SPAN (SEARCH_SPAN)
  ) u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .ctl                     (ctl),
    .sts                     (sts),
    .cfg                     (cfg),
    .in_command              (in_command),
    .in_reachable            (in_reachable),
    .in_send_count           (in_send_count),
    .in_payload_first_byte   (in_payload_first_byte),
    .in_fragment_ok          (in_fragment_ok),
    .out_tx_freq             (out_tx_freq),
    .out_rx_freq             (out_rx_freq),
    .out_send_change_channel (out_send_change_channel),
    .out_good_freq_out       (out_good_freq_out)
  );

endmodule

FILE: bench/radio_channel_search_selector_tb.sv
module radio_channel_search_selector_tb;
  import rcss_pkg::*;

  localparam int SEARCH_SPAN = 20;
  localparam logic [1:0] CMD_QUERY = 2'd0;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned MAX_HZ = 1_000_000_000;
  localparam int unsigned MAX_CW = 16_777_215;
  localparam int PHASE_ITEMS = 95;
  localparam int SAT_FETCHES = 32_770;

  typedef struct {
    logic [1:0] command;
    logic       reachable;
    logic [7:0] send_count;
    logic [7:0] first_byte;
    logic       frag_ok;
  } fetch_cmd_t;

  typedef struct {
    logic [29:0] tx;
    logic [29:0] rx;
    logic        chg;
    logic [29:0] good;
  } freq_choice_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_command = '0;
  logic in_reachable = 1'b0;
  logic [7:0] in_send_count = '0;
  logic [7:0] in_payload_first_byte = '0;
  logic in_fragment_ok = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [29:0] out_tx_freq;
  logic [29:0] out_rx_freq;
  logic out_send_change_channel;
  logic [29:0] out_good_freq_out;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  logic [29:0] cfg_target = TARGET_RST;
  logic [29:0] cfg_boot = BOOT_RST;
  logic [29:0] cfg_min = MIN_RST;
  logic [29:0] cfg_max = MAX_RST;
  logic [29:0] cfg_lmin = LMIN_RST;
  logic [29:0] cfg_lmax = LMAX_RST;
  logic [23:0] cfg_cw = CW_RST;
  logic [29:0] good_freq = '0;
  int fail_cnt = 0;

  fetch_cmd_t pending_cmds[$];
  freq_choice_t expected_choices[$];
  fetch_cmd_t cur_cmd;
  bit idle_on = 1'b1;
  int in_hold = 0;
  int rdy_wait = 0;
  int draw_out;
  int cmds_queued = 0;
  int cmds_taken = 0;
  int choices_seen = 0;
  int mismatches = 0;
  int search_cnt = 0;
  int change_cnt = 0;
  int peak_fail = 0;
  int cfg_sets = 1;

  radio_channel_search_selector #(.SEARCH_SPAN(SEARCH_SPAN)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_command(in_command),
    .in_reachable(in_reachable),
    .in_send_count(in_send_count),
    .in_payload_first_byte(in_payload_first_byte),
    .in_fragment_ok(in_fragment_ok),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_tx_freq(out_tx_freq),
    .out_rx_freq(out_rx_freq),
    .out_send_change_channel(out_send_change_channel),
    .out_good_freq_out(out_good_freq_out),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("Timeout with %0d of %0d commands taken.", cmds_taken, cmds_queued);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [29:0] zigzag_freq(input int sends);
    longint done, off, lo_u, hi_u, t, cw, lo_off, hi_off, span, m, f;
    done = sends - 2;
    off = (longint'(fail_cnt) - 1 + done / 2) % SEARCH_SPAN;
    lo_u = (cfg_min > cfg_lmin) ? cfg_min : cfg_lmin;
    hi_u = (cfg_max < cfg_lmax) ? cfg_max : cfg_lmax;
    t = cfg_target;
    cw = cfg_cw;
    if (cw == 0) return cfg_target;
    if (done % 2 == 0) off = -off;
    lo_off = -((t - lo_u) / cw);
    hi_off = (hi_u - t) / cw;
    span = hi_off + 1 - lo_off;
    if (span <= 0) return cfg_target;
    m = ((off - lo_off) % span + span) % span;
    f = t + (m + lo_off) * cw;
    if (f < 0) f = 0;
    return f[29:0];
  endfunction

  // Frequencies come from the state before the command; the good frequency after it.
  function automatic freq_choice_t select_freqs(input fetch_cmd_t c);
    freq_choice_t r;
    int sends;
    logic [29:0] f;
    logic change;
    sends = (c.send_count == 8'd0) ? 1 : int'(c.send_count);
    if (c.reachable || fail_cnt <= 0) begin
      if (good_freq == cfg_target || good_freq == '0) f = cfg_target;
      else f = ((sends - 1) % 2 == 0) ? good_freq : cfg_target;
    end else if (sends == 1) begin
      f = cfg_target;
    end else begin
      f = zigzag_freq(sends);
      search_cnt++;
    end
    change = (c.first_byte == CHG_MARK);
    if (change) change_cnt++;
    r.tx = change ? cfg_boot : f;
    r.rx = change ? cfg_target : f;
    if (!c.reachable) r.chg = 1'b1;
    else if (good_freq == '0) r.chg = 1'b0;
    else r.chg = (good_freq != cfg_target);
    if (c.command == CMD_RX) begin
      if (c.frag_ok) begin
        good_freq = r.rx;
        fail_cnt = -1;
      end
    end else if (c.command == CMD_FETCH) begin
      if (c.reachable) fail_cnt = 0;
      else if (fail_cnt < FAIL_MAX) fail_cnt++;
    end
    if (fail_cnt > peak_fail) peak_fail = fail_cnt;
    r.good = good_freq;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < 40) $display("MISMATCH at result %0d: %s", choices_seen, what);
    mismatches++;
  endtask

  task automatic check_choice();
    freq_choice_t want;
    if (expected_choices.size() == 0) begin
      report_mismatch("result transfer with nothing expected");
    end else begin
      want = expected_choices.pop_front();
      if (out_tx_freq !== want.tx)
        report_mismatch($sformatf("tx_freq %0d, expected %0d", out_tx_freq, want.tx));
      if (out_rx_freq !== want.rx)
        report_mismatch($sformatf("rx_freq %0d, expected %0d", out_rx_freq, want.rx));
      if (out_send_change_channel !== want.chg)
        report_mismatch($sformatf("send_change_channel %b, expected %b",
                                  out_send_change_channel, want.chg));
      if (out_good_freq_out !== want.good)
        report_mismatch($sformatf("good_freq_out %0d, expected %0d",
                                  out_good_freq_out, want.good));
    end
    choices_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_hold <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_choices.push_back(select_freqs(cur_cmd));
        cmds_taken++;
      end
      if (!in_valid || in_ready) begin
        if (in_hold > 0) begin
          in_valid <= 1'b0;
          in_hold <= in_hold - 1;
        end else if (pending_cmds.size() != 0) begin
          cur_cmd = pending_cmds.pop_front();
          in_command <= cur_cmd.command;
          in_reachable <= cur_cmd.reachable;
          in_send_count <= cur_cmd.send_count;
          in_payload_first_byte <= cur_cmd.first_byte;
          in_fragment_ok <= cur_cmd.frag_ok;
          in_valid <= 1'b1;
          in_hold <= idle_on ? $urandom_range(0, 7) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rdy_wait <= 0;
    end else if (out_valid && out_ready) begin
      check_choice();
      draw_out = idle_on ? $urandom_range(0, 7) : 0;
      if (draw_out != 0) begin
        out_ready <= 1'b0;
        rdy_wait <= draw_out - 1;
      end
    end else if (!out_ready) begin
      if (rdy_wait == 0) out_ready <= 1'b1;
      else rdy_wait <= rdy_wait - 1;
    end
  end

  task automatic push_cmd(input logic [1:0] c, input logic r, input logic [7:0] s,
                          input logic [7:0] p, input logic ok);
    fetch_cmd_t item;
    item.command = c;
    item.reachable = r;
    item.send_count = s;
    item.first_byte = p;
    item.frag_ok = ok;
    pending_cmds.push_back(item);
    cmds_queued++;
  endtask

  function automatic logic [7:0] rand_first_byte();
    return ($urandom_range(0, 3) == 0) ? CHG_MARK : 8'($urandom_range(0, 255));
  endfunction

  task automatic wait_drained();
    do @(negedge clk); while (cmds_taken != cmds_queued || expected_choices.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_TARGET: cfg_target = val[29:0];
      REG_BOOT: cfg_boot = val[29:0];
      REG_MIN: cfg_min = val[29:0];
      REG_MAX: cfg_max = val[29:0];
      REG_LMIN: cfg_lmin = val[29:0];
      REG_LMAX: cfg_lmax = val[29:0];
      REG_CW: cfg_cw = val[23:0];
      default: ;
    endcase
  endtask

  task automatic apply_cfg(input logic [29:0] t, input logic [29:0] b, input logic [29:0] lo,
                           input logic [29:0] hi, input logic [29:0] llo,
                           input logic [29:0] lhi, input logic [23:0] w);
    reg_write(REG_TARGET, {2'b00, t});
    reg_write(REG_BOOT, {2'b00, b});
    reg_write(REG_MIN, {2'b00, lo});
    reg_write(REG_MAX, {2'b00, hi});
    reg_write(REG_LMIN, {2'b00, llo});
    reg_write(REG_LMAX, {2'b00, lhi});
    reg_write(REG_CW, {8'h00, w});
    cfg_sets++;
  endtask

  task automatic rand_band_cfg();
    int unsigned t, w;
    t = $urandom_range(100_000_000, 900_000_000);
    w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5000) : $urandom_range(50_000, 2_000_000);
    apply_cfg(t, $urandom_range(0, MAX_HZ), t - $urandom_range(0, 20_000_000),
              t + $urandom_range(0, 60_000_000), t - $urandom_range(0, 8_000_000),
              t + $urandom_range(0, 8_000_000), w);
  endtask

  task automatic wild_cfg();
    apply_cfg($urandom_range(0, MAX_HZ), $urandom_range(0, MAX_HZ), $urandom_range(0, MAX_HZ),
              $urandom_range(0, MAX_HZ), $urandom_range(0, MAX_HZ), $urandom_range(0, MAX_HZ),
              $urandom_range(1, MAX_CW));
  endtask

  // Most rounds are fetch starts followed by the retransmissions of one packet.
  task automatic gen_round();
    int n, base, k;
    case ($urandom_range(0, 5))
      0: push_cmd($urandom_range(0, 3), $urandom_range(0, 1), $urandom_range(0, 255),
                  $urandom_range(0, 255), $urandom_range(0, 1));
      1: push_cmd(CMD_RX, $urandom_range(0, 1), $urandom_range(1, 255), rand_first_byte(),
                  $urandom_range(0, 3) != 0);
      default: begin
        n = $urandom_range(0, 4);
        repeat (n) push_cmd(CMD_FETCH, $urandom_range(0, 5) == 0, 8'd1,
                            $urandom_range(0, 255), $urandom_range(0, 1));
        base = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 240) : 1;
        k = $urandom_range(1, 12);
        for (int s = 0; s < k; s++)
          push_cmd(CMD_QUERY, $urandom_range(0, 4) == 0, 8'(base + s), rand_first_byte(),
                   $urandom_range(0, 1));
        if ($urandom_range(0, 2) == 0)
          push_cmd(CMD_RX, $urandom_range(0, 3) == 0, 8'(base + k - 1), rand_first_byte(),
                   $urandom_range(0, 3) != 0);
      end
    endcase
  endtask

  task automatic random_phase();
    int start;
    idle_on = ($urandom_range(0, 3) != 0);
    start = cmds_queued;
    while (cmds_queued - start < PHASE_ITEMS) gen_round();
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    push_cmd(CMD_QUERY, 1'b1, 8'd1, 8'h00, 1'b0);
    push_cmd(CMD_QUERY, 1'b0, 8'd1, CHG_MARK, 1'b0);
    push_cmd(CMD_FETCH, 1'b0, 8'd1, 8'h00, 1'b0);
    push_cmd(CMD_FETCH, 1'b0, 8'd1, 8'hFF, 1'b1);
    for (int s = 1; s <= 5; s++) push_cmd(CMD_QUERY, 1'b0, 8'(s), 8'h00, 1'b0);
    push_cmd(CMD_QUERY, 1'b0, 8'd0, 8'h00, 1'b0);
    push_cmd(CMD_QUERY, 1'b0, 8'd255, 8'hFF, 1'b1);
    push_cmd(CMD_RX, 1'b0, 8'd3, 8'h00, 1'b0);
    push_cmd(CMD_RX, 1'b0, 8'd3, 8'h00, 1'b1);
    push_cmd(CMD_QUERY, 1'b1, 8'd1, 8'h00, 1'b0);
    push_cmd(CMD_QUERY, 1'b1, 8'd2, 8'h00, 1'b0);
    push_cmd(CMD_UNUSED, 1'b0, 8'd7, CHG_MARK, 1'b1);
    push_cmd(CMD_FETCH, 1'b1, 8'd1, 8'h00, 1'b0);
    push_cmd(CMD_QUERY, 1'b0, 8'd2, 8'h00, 1'b0);
    push_cmd(CMD_FETCH, 1'b0, 8'd1, 8'h00, 1'b0);
    push_cmd(CMD_QUERY, 1'b0, 8'd6, CHG_MARK, 1'b0);
    push_cmd(CMD_QUERY, 1'b0, 8'd7, 8'h55, 1'b0);
    push_cmd(CMD_RX, 1'b1, 8'd1, 8'h00, 1'b1);
    push_cmd(CMD_QUERY, 1'b1, 8'd128, 8'h57, 1'b0);
    wait_drained();

    random_phase();
    apply_cfg('0, '0, '0, '0, '0, '0, 24'd1);
    random_phase();
    apply_cfg(MAX_HZ, MAX_HZ, MAX_HZ, MAX_HZ, MAX_HZ, MAX_HZ, MAX_CW);
    random_phase();
    apply_cfg($urandom_range(0, MAX_HZ), $urandom_range(0, MAX_HZ), '0, MAX_HZ, '0, MAX_HZ,
              24'd1);
    random_phase();
    apply_cfg(TARGET_RST, BOOT_RST, MIN_RST, MAX_RST, LMIN_RST, LMAX_RST, '0);
    random_phase();
    apply_cfg(TARGET_RST, 30'd869000000, MIN_RST, MAX_RST, LMAX_RST, LMIN_RST, CW_RST);
    random_phase();
    apply_cfg(30'd900000000, BOOT_RST, MIN_RST, MAX_RST, LMIN_RST, LMAX_RST, CW_RST);
    random_phase();
    repeat (3) begin
      wild_cfg();
      random_phase();
    end
    repeat (3) begin
      rand_band_cfg();
      random_phase();
    end

    // Drive the failure count into saturation, then search from there.
    rand_band_cfg();
    idle_on = 1'b0;
    push_cmd(CMD_FETCH, 1'b1, 8'd1, 8'h00, 1'b0);
    repeat (SAT_FETCHES) push_cmd(CMD_FETCH, 1'b0, 8'd1, 8'h00, 1'b0);
    for (int s = 1; s <= 8; s++) push_cmd(CMD_QUERY, 1'b0, 8'(s), 8'h00, 1'b0);
    push_cmd(CMD_FETCH, 1'b0, 8'd1, 8'h00, 1'b0);
    push_cmd(CMD_QUERY, 1'b0, 8'd3, 8'h00, 1'b0);
    wait_drained();

    repeat (100) @(negedge clk);
    $display("Checked %0d results over %0d register settings: %0d zigzag searches, %0d %s",
             choices_seen, cfg_sets, search_cnt, change_cnt, "change-channel packets.");
    $display("Peak failed-fetch count %0d; %0d mismatches.", peak_fail, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
